// File: rtl/u8u16_pkg.sv
// Shared types, constants and helper functions of the UTF-8 to UTF-16 transcoder.
`default_nettype none
package u8u16_pkg;

  localparam int unsigned MAX_INPUT_BYTES = 1048576;
  localparam int unsigned IN_CNT_W        = $clog2(MAX_INPUT_BYTES + 1);
  localparam logic [IN_CNT_W:0] MAX_IN_CMP = (IN_CNT_W + 1)'(MAX_INPUT_BYTES);

  localparam int unsigned OUT_CNT_W = 22;
  localparam int unsigned CAP_W     = 24;
  localparam int unsigned PEND_W    = 24;

  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int unsigned MAX_RES   = 3;

  // Result kinds.
  localparam logic [1:0] KIND_UNIT    = 2'd0;
  localparam logic [1:0] KIND_SUCCESS = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // Decoder phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_BAD     = 2'd2;
  localparam logic [1:0] PH_SWALLOW = 2'd3;

  // Configuration register indexes.
  localparam logic REG_TRUNCATE = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [PEND_W-1:0] SUPP_BASE = 24'h010000;
  localparam logic [15:0]       HI_SURR   = 16'hd800;
  localparam logic [15:0]       LO_SURR   = 16'hdc00;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] out_bytes;
    logic                 is_last;
    logic [1:0]           kind;
    logic [15:0]          code_unit;
  } res_t;

  typedef struct packed {
    logic [1:0]           cnt;
    res_t [MAX_RES-1:0]   item;
  } push_t;

  function automatic res_t mk_unit(input logic [15:0] unit);
    res_t r;
    r.out_bytes = '0;
    r.is_last   = 1'b0;
    r.kind      = KIND_UNIT;
    r.code_unit = unit;
    return r;
  endfunction

  function automatic res_t mk_term(input logic [1:0] kind,
                                   input logic [OUT_CNT_W-1:0] outc);
    res_t r;
    r.out_bytes = (kind == KIND_SUCCESS) ? outc + OUT_CNT_W'(2) : '0;
    r.is_last   = 1'b1;
    r.kind      = kind;
    r.code_unit = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/u8u16_decode.sv
// Per-byte decoder: string state registers and the single-pass step that yields up to three results.
`default_nettype none
module u8u16_decode (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           eos,
  input  wire logic                           trunc,
  input  wire logic [u8u16_pkg::CAP_W-1:0]    cap,
  output u8u16_pkg::push_t                    push
);

  logic [1:0]                         ph_r, ph_nxt;
  logic [u8u16_pkg::PEND_W-1:0]       pend_r, pend_nxt;
  logic [2:0]                         exp_r, exp_nxt;
  logic [1:0]                         have_r, have_nxt;
  logic [u8u16_pkg::IN_CNT_W-1:0]     inc_r, inc_nxt;
  logic [u8u16_pkg::OUT_CNT_W-1:0]    outc_r, outc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= u8u16_pkg::PH_IDLE;
      pend_r <= '0;
      exp_r  <= '0;
      have_r <= '0;
      inc_r  <= '0;
      outc_r <= '0;
    end else begin
      ph_r   <= ph_nxt;
      pend_r <= pend_nxt;
      exp_r  <= exp_nxt;
      have_r <= have_nxt;
      inc_r  <= inc_nxt;
      outc_r <= outc_nxt;
    end
  end

  always_comb begin
    logic                             first;
    logic                             last;
    logic                             do_term;
    logic [1:0]                       term_kind;
    logic [1:0]                       nres;
    logic [2:0]                       len;
    logic [u8u16_pkg::PEND_W-1:0]     lead;
    logic [u8u16_pkg::CAP_W-1:0]      need;
    logic [u8u16_pkg::CAP_W-1:0]      outc_ext;
    logic [1:0]                       have_upd;
    logic [u8u16_pkg::PEND_W-1:0]     pend_upd;
    logic [u8u16_pkg::PEND_W-1:0]     cp;
    logic                             bad;

    ph_nxt    = ph_r;
    pend_nxt  = pend_r;
    exp_nxt   = exp_r;
    have_nxt  = have_r;
    inc_nxt   = inc_r;
    outc_nxt  = outc_r;
    push      = '0;
    do_term   = 1'b0;
    term_kind = u8u16_pkg::KIND_SUCCESS;
    nres      = 2'd0;
    len       = 3'd0;
    lead      = '0;
    need      = u8u16_pkg::CAP_W'(2);
    outc_ext  = u8u16_pkg::CAP_W'(outc_r);
    have_upd  = have_r + 2'd1;
    pend_upd  = {pend_r[u8u16_pkg::PEND_W-7:0], in_byte[5:0]};
    cp        = pend_upd - u8u16_pkg::SUPP_BASE;
    bad       = (ph_r == u8u16_pkg::PH_BAD) || (in_byte[7:6] != 2'b10);
    first     = (inc_r == '0);
    last      = eos || (({1'b0, inc_r} + 1'b1) >= u8u16_pkg::MAX_IN_CMP);

    if (step) begin
      if (ph_r == u8u16_pkg::PH_SWALLOW) begin
        if (eos) begin
          ph_nxt   = u8u16_pkg::PH_IDLE;
          pend_nxt = '0;
          exp_nxt  = '0;
          have_nxt = '0;
          inc_nxt  = '0;
          outc_nxt = '0;
        end
      end else begin
        inc_nxt = inc_r + 1'b1;
        if (ph_r == u8u16_pkg::PH_IDLE) begin
          priority if (first && trunc && (cap == '0)) begin
            do_term   = 1'b1;
            term_kind = u8u16_pkg::KIND_INVALID;
          end else if (in_byte == 8'h00) begin
            do_term = 1'b1;
          end else if (!in_byte[7]) begin
            if (trunc && (outc_ext + need >= cap)) begin
              do_term = 1'b1;
            end else begin
              push.item[0] = u8u16_pkg::mk_unit({8'h00, in_byte});
              nres         = 2'd1;
              outc_nxt     = outc_r + u8u16_pkg::OUT_CNT_W'(2);
              do_term      = last;
            end
          end else begin
            priority if (in_byte[7:5] == 3'b110) begin
              len  = 3'd2;
              lead = u8u16_pkg::PEND_W'(in_byte[4:0]);
            end else if (in_byte[7:4] == 4'b1110) begin
              len  = 3'd3;
              lead = u8u16_pkg::PEND_W'(in_byte[3:0]);
            end else if (in_byte[7:3] == 5'b11110) begin
              len  = 3'd4;
              lead = u8u16_pkg::PEND_W'(in_byte[2:0]);
            end else begin
              len  = 3'd0;
            end
            if (len == 3'd4) begin
              need = u8u16_pkg::CAP_W'(4);
            end
            if (len == 3'd0) begin
              do_term = 1'b1;
            end else begin
              pend_nxt = lead;
              if (trunc && (outc_ext + need >= cap)) begin
                do_term = 1'b1;
              end else begin
                exp_nxt  = len;
                have_nxt = 2'd0;
                ph_nxt   = u8u16_pkg::PH_COLLECT;
                do_term  = last;
              end
            end
          end
        end else begin
          have_nxt = have_upd;
          pend_nxt = pend_upd;
          if (bad) begin
            ph_nxt = u8u16_pkg::PH_BAD;
          end
          if (({1'b0, have_upd} + 3'd1) >= exp_r) begin
            if (bad) begin
              do_term   = 1'b1;
              term_kind = u8u16_pkg::KIND_INVALID;
            end else begin
              if (pend_upd >= u8u16_pkg::SUPP_BASE) begin
                push.item[0] = u8u16_pkg::mk_unit(
                  16'(cp[u8u16_pkg::PEND_W-1:10]) + u8u16_pkg::HI_SURR);
                push.item[1] = u8u16_pkg::mk_unit(
                  {6'd0, cp[9:0]} + u8u16_pkg::LO_SURR);
                nres     = 2'd2;
                outc_nxt = outc_r + u8u16_pkg::OUT_CNT_W'(4);
              end else begin
                push.item[0] = u8u16_pkg::mk_unit(pend_upd[15:0]);
                nres         = 2'd1;
                outc_nxt     = outc_r + u8u16_pkg::OUT_CNT_W'(2);
              end
              ph_nxt   = u8u16_pkg::PH_IDLE;
              pend_nxt = '0;
              exp_nxt  = '0;
              have_nxt = '0;
              do_term  = last;
            end
          end else begin
            do_term = last;
          end
        end

        push.cnt = nres;
        if (do_term) begin
          push.item[nres] = u8u16_pkg::mk_term(term_kind, outc_nxt);
          push.cnt        = nres + 2'd1;
          if (eos) begin
            ph_nxt   = u8u16_pkg::PH_IDLE;
            pend_nxt = '0;
            exp_nxt  = '0;
            have_nxt = '0;
            inc_nxt  = '0;
            outc_nxt = '0;
          end else begin
            ph_nxt = u8u16_pkg::PH_SWALLOW;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/u8u16_fifo.sv
// Result queue: takes up to three results a cycle and hands out one a cycle while pop is asserted.
`default_nettype none
module u8u16_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire u8u16_pkg::push_t   push,
  input  wire logic               pop,
  output u8u16_pkg::res_t         head,
  output logic                    head_valid,
  output logic                    room
);

  u8u16_pkg::res_t                     mem_r [u8u16_pkg::RES_DEPTH];
  logic [u8u16_pkg::RES_PTR_W-1:0]     wptr_r, wptr_nxt;
  logic [u8u16_pkg::RES_PTR_W-1:0]     rptr_r, rptr_nxt;
  logic [u8u16_pkg::RES_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                                do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rptr_r];
  assign do_pop     = pop && head_valid;
  assign room       = (cnt_r <= u8u16_pkg::RES_CNT_W'(u8u16_pkg::RES_DEPTH
                                                      - u8u16_pkg::MAX_RES));
  assign wptr_nxt   = wptr_r + u8u16_pkg::RES_PTR_W'(push.cnt);
  assign rptr_nxt   = rptr_r + u8u16_pkg::RES_PTR_W'(do_pop);
  assign cnt_nxt    = cnt_r + u8u16_pkg::RES_CNT_W'(push.cnt)
                      - u8u16_pkg::RES_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < u8u16_pkg::MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wptr_r + u8u16_pkg::RES_PTR_W'(i)] <= push.item[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/utf8_to_utf16_transcoder_core.sv
// Top level of the UTF-8 to UTF-16 transcoder: stream ports, register port and input stage.
// An accepted byte is held in the input register and decoded once the result queue has room;
// its results are written into the queue, whose head drives the output stream.
// Throughput: one byte per cycle while each byte yields at most one result and out_tready
// stays high; the queue drains one result per cycle, so surrogate pairs and terminators stall.
// Reset (synchronous, active low) clears the string state, the queue and both registers.
`default_nettype none
module utf8_to_utf16_transcoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] code_unit, [37:16] out_bytes, [39:38] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic                              trunc_r;
  logic [u8u16_pkg::CAP_W-1:0]       cap_r;
  logic                              stage_v_r;
  logic [7:0]                        stage_byte_r;
  logic                              stage_eos_r;
  logic                              fire;
  logic                              room;
  logic                              cfg_wr;
  u8u16_pkg::push_t                  push;
  u8u16_pkg::res_t                   head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == u8u16_pkg::REG_CAPACITY) ? 32'(cap_r) : 32'(trunc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r <= 1'b0;
      cap_r   <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == u8u16_pkg::REG_CAPACITY) begin
        cap_r <= cfg_pwdata[u8u16_pkg::CAP_W-1:0];
      end else begin
        trunc_r <= cfg_pwdata[0];
      end
    end
  end

  assign fire      = stage_v_r && room;
  assign in_tready = !stage_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_tready) begin
      stage_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stage_byte_r <= in_tdata;
      stage_eos_r  <= in_tlast;
    end
  end

  u8u16_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (fire),
    .in_byte (stage_byte_r),
    .eos     (stage_eos_r),
    .trunc   (trunc_r),
    .cap     ({cap_r[u8u16_pkg::CAP_W-1:1], 1'b0}),
    .push    (push)
  );

  u8u16_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room)
  );

  assign out_tdata = {2'b00, head.out_bytes, head.code_unit};
  assign out_tuser = head.kind;
  assign out_tlast = head.is_last;

endmodule
`default_nettype wire

// File: rtl/u8u16_checker.sv
// Port-level checker for the transcoder result stream, bound to the top level.
`default_nettype none
module u8u16_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result request keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Code units are never marked last and carry no byte count.
  a_unit_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == u8u16_pkg::KIND_UNIT
      && out_tdata[37:16] == 22'd0)
    else $error("malformed code unit result");

  // An invalid terminator reports zero bytes and a zero unit.
  a_invalid_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == u8u16_pkg::KIND_INVALID |->
      out_tlast && out_tdata[37:0] == 38'd0)
    else $error("malformed invalid terminator");

  // A success terminator reports an even, non-zero byte count.
  a_success_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == u8u16_pkg::KIND_SUCCESS |->
      out_tlast && out_tdata[15:0] == 16'd0 && !out_tdata[16]
      && out_tdata[37:16] != 22'd0)
    else $error("malformed success terminator");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_port_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// File: test/u8u16_checker.sv
// Checker for the UTF-8 to UTF-16 transcoder: predicts and compares the results.
module u8u16_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,  // [15:0] code_unit, [37:16] out_bytes, [39:38] zero
  input  wire logic [1:0]  out_tuser,  // [1:0] kind
  input  wire logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               units_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [21:0] nbytes;
    logic        last;
    logic [1:0]  kind;
    logic [15:0] unit;
  } utf16_res_t;

  utf16_res_t  due_q[$];

  logic        trunc_en;
  logic [23:0] cap_reg;
  logic [1:0]  ph;
  logic [23:0] pend;
  int unsigned want_len;
  int unsigned got_len;
  int unsigned in_cnt;
  int unsigned out_cnt;

  task automatic clear_string();
    ph       = u8u16_pkg::PH_IDLE;
    pend     = '0;
    want_len = 0;
    got_len  = 0;
    in_cnt   = 0;
    out_cnt  = 0;
  endtask

  task automatic push_res(input logic [15:0] unit, input logic [1:0] kind,
                          input int unsigned nbytes);
    utf16_res_t r;
    r.unit   = unit;
    r.kind   = kind;
    r.last   = (kind != u8u16_pkg::KIND_UNIT);
    r.nbytes = 22'(nbytes);
    due_q.push_back(r);
  endtask

  task automatic close_string(input logic [1:0] kind, input bit eos);
    push_res(16'h0000, kind, (kind == u8u16_pkg::KIND_SUCCESS) ? out_cnt + 2 : 0);
    if (eos) begin
      clear_string();
    end else begin
      ph = u8u16_pkg::PH_SWALLOW;
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input bit eos);
    int unsigned cap;
    int unsigned cp;
    int unsigned len;
    int unsigned need;
    bit          first;
    bit          last_byte;
    cap = int'(cap_reg) & 32'h00ff_fffe;
    if (ph == u8u16_pkg::PH_SWALLOW) begin
      if (eos) clear_string();
      return;
    end
    first     = (in_cnt == 0);
    last_byte = eos || (in_cnt + 1 >= u8u16_pkg::MAX_INPUT_BYTES);
    in_cnt++;
    if (ph == u8u16_pkg::PH_IDLE) begin
      if (first && trunc_en && cap == 0) begin
        close_string(u8u16_pkg::KIND_INVALID, eos);
        return;
      end
      if (c == 8'h00) begin
        close_string(u8u16_pkg::KIND_SUCCESS, eos);
        return;
      end
      if (c < 8'h80) begin
        if (trunc_en && out_cnt + 2 >= cap) begin
          close_string(u8u16_pkg::KIND_SUCCESS, eos);
          return;
        end
        push_res({8'h00, c}, u8u16_pkg::KIND_UNIT, 0);
        out_cnt += 2;
        if (last_byte) close_string(u8u16_pkg::KIND_SUCCESS, eos);
        return;
      end
      len = 0;
      if (c[7:5] == 3'b110) begin
        len  = 2;
        pend = {19'h0, c[4:0]};
      end
      if (c[7:4] == 4'b1110) begin
        len  = 3;
        pend = {20'h0, c[3:0]};
      end
      if (c[7:3] == 5'b11110) begin
        len  = 4;
        pend = {21'h0, c[2:0]};
      end
      if (len == 0) begin
        close_string(u8u16_pkg::KIND_SUCCESS, eos);
        return;
      end
      need = (len == 4) ? 4 : 2;
      if (trunc_en && out_cnt + need >= cap) begin
        close_string(u8u16_pkg::KIND_SUCCESS, eos);
        return;
      end
      want_len = len;
      got_len  = 0;
      ph       = u8u16_pkg::PH_COLLECT;
      if (last_byte) close_string(u8u16_pkg::KIND_SUCCESS, eos);
      return;
    end
    got_len = (got_len + 1) & 3;
    pend    = {pend[17:0], c[5:0]};
    if (c[7:6] != 2'b10) ph = u8u16_pkg::PH_BAD;
    if (got_len + 1 >= want_len) begin
      if (ph == u8u16_pkg::PH_BAD) begin
        close_string(u8u16_pkg::KIND_INVALID, eos);
        return;
      end
      cp = int'(pend);
      if (cp >= 32'h1_0000) begin
        cp -= 32'h1_0000;
        push_res(16'((cp >> 10) + 32'hd800), u8u16_pkg::KIND_UNIT, 0);
        push_res(16'((cp & 32'h3ff) + 32'hdc00), u8u16_pkg::KIND_UNIT, 0);
        out_cnt += 4;
      end else begin
        push_res(16'(cp), u8u16_pkg::KIND_UNIT, 0);
        out_cnt += 2;
      end
      ph       = u8u16_pkg::PH_IDLE;
      pend     = '0;
      want_len = 0;
      got_len  = 0;
      if (last_byte) close_string(u8u16_pkg::KIND_SUCCESS, eos);
      return;
    end
    if (last_byte) close_string(u8u16_pkg::KIND_SUCCESS, eos);
  endtask

  always @(posedge clk) begin : watch
    utf16_res_t got;
    utf16_res_t want;
    if (!rst_n) begin
      trunc_en = 1'b0;
      cap_reg  = '0;
      clear_string();
      due_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == u8u16_pkg::REG_CAPACITY) begin
          cap_reg = cfg_pwdata[23:0];
        end else begin
          trunc_en = cfg_pwdata[0];
        end
      end
      if (out_tvalid && out_tready) begin
        got.unit   = out_tdata[15:0];
        got.nbytes = out_tdata[37:16];
        got.kind   = out_tuser;
        got.last   = out_tlast;
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, ", $time,
                   "got unit=%h kind=%0d last=%0d bytes=%0d",
                   got.unit, got.kind, got.last, got.nbytes);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected unit=%h kind=%0d last=%0d bytes=%0d, ",
                     $time, want.unit, want.kind, want.last, want.nbytes,
                     "got unit=%h kind=%0d last=%0d bytes=%0d",
                     got.unit, got.kind, got.last, got.nbytes);
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    units_due = due_q.size();
  end

endmodule

// File: test/tb.sv
// Testbench top for the UTF-8 to UTF-16 transcoder: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ADDR_TRUNCATE = {u8u16_pkg::REG_TRUNCATE, 2'b00};
  localparam logic [2:0] ADDR_CAPACITY = {u8u16_pkg::REG_CAPACITY, 2'b00};

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;  // [7:0] in_byte
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;            // [15:0] code_unit, [37:16] out_bytes, [39:38] zero
  logic [1:0]  out_tuser;            // [1:0] kind
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = 3'd0;
  logic [31:0] cfg_pwdata  = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic        steady      = 1'b0;
  int          mismatches;
  int          units_due;
  int          cycles      = 0;
  int          bytes_sent  = 0;
  logic [7:0]  text_q[$];

  always #5ns clk = ~clk;

  utf8_to_utf16_transcoder_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  u8u16_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .units_due   (units_due)
  );

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic put_seq(input logic [20:0] cp, input int len);
    case (len)
      1: text_q.push_back({1'b0, cp[6:0]});
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Mostly well-formed characters, with NULs, bad lead bytes, bad continuations and cut
  // sequences mixed in; a cut sequence always closes the string.
  task automatic random_text();
    int          n_chars;
    int          pick;
    int          len;
    int          pos;
    int          k;
    logic [7:0]  b;
    n_chars = $urandom_range(1, 8);
    for (int i = 0; i < n_chars; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        put_seq(21'($urandom_range(1, 127)), 1);
      end else if (pick < 85) begin
        len = (pick < 55) ? 2 : (pick < 70) ? 3 : 4;
        put_seq(21'($urandom), len);
      end else if (pick < 89) begin
        text_q.push_back(8'h00);
      end else if (pick < 93) begin
        b = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hbf))
                                 : 8'($urandom_range(8'hf8, 8'hff));
        text_q.push_back(b);
      end else if (pick < 97) begin
        len = $urandom_range(2, 4);
        put_seq(21'($urandom), len);
        pos = text_q.size() - 1 - $urandom_range(0, len - 2);
        b = 8'($urandom);
        k = $urandom_range(0, 2);
        b[7:6] = (k == 2) ? 2'b11 : 2'(k);
        text_q[pos] = b;
      end else begin
        len = $urandom_range(2, 4);
        put_seq(21'($urandom), len);
        k = $urandom_range(1, len - 1);
        repeat (len - k) text_q.delete(text_q.size() - 1);
        break;
      end
    end
    send_text();
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic configure(input logic trunc, input logic [23:0] cap);
    write_reg(ADDR_TRUNCATE, {31'($urandom), trunc});
    write_reg(ADDR_CAPACITY, {8'($urandom), cap});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (units_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int goal;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no capacity limit.
    text_q = '{8'h41, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80,
               8'hff, 8'h20, 8'h00};
    send_text();
    text_q = '{8'h00};
    send_text();
    text_q = '{8'he2, 8'h41, 8'h82};
    send_text();
    text_q = '{8'hf4, 8'h8f};
    send_text();
    text_q = '{8'h7f, 8'h80};
    send_text();
    text_q = '{8'hf7, 8'hbf, 8'hbf, 8'hbf};
    send_text();
    settle();

    configure(1'b1, 24'h000000);
    text_q = '{8'h41, 8'h42};
    send_text();
    settle();
    configure(1'b1, 24'h000001);
    text_q = '{8'h41};
    send_text();
    settle();
    configure(1'b1, 24'h000007);
    text_q = '{8'h41, 8'h42, 8'h43};
    send_text();
    text_q = '{8'h41, 8'hf0, 8'h9f, 8'h98, 8'h80};
    send_text();
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       configure(1'b0, 24'($urandom));
        1:       configure(1'b1, 24'hffffff);
        2:       configure(1'b1, 24'($urandom_range(2, 40)));
        3:       configure(1'b1, 24'($urandom_range(0, 3)));
        4:       configure(1'b1, 24'($urandom_range(8, 64)));
        default: configure(1'b0, 24'h000000);
      endcase
      steady <= (p == 2);
      goal = bytes_sent + 15;
      while (bytes_sent < goal) random_text();
      settle();
    end

    if (mismatches == 0 && units_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
